[design/pfat_pkg.sv]
package pfat_pkg;

  localparam int NUM_FRAMES    = 64;
  localparam int MAX_PROCESSES = 16;

  localparam int FW    = $clog2(NUM_FRAMES);
  localparam int CW    = $clog2(NUM_FRAMES + 1);
  localparam int PIDW  = 4;
  localparam int MAPAW = $clog2(MAX_PROCESSES * NUM_FRAMES);
  localparam int PSW   = 17;
  localparam int DVW   = 24;
  localparam int PAW   = 22;
  localparam int NEEDW = DVW + 1;
  localparam int PRODW = FW + PSW;

  localparam logic [PSW-1:0] PS_RESET = PSW'(4096);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FREE  = 2'd1,
    OP_XLATE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t             action;
    logic [PIDW-1:0] process_id;
    logic [DVW-1:0]  memory_size;
    logic [DVW-1:0]  logical_address;
  } in_t;

  typedef struct packed {
    logic           ok;
    logic [PAW-1:0] physical_address;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_LOAD_CHK,
    ST_LOAD_SCAN,
    ST_TR_CHK,
    ST_TR_LOOK,
    ST_TR_SCAN,
    ST_TR_MUL,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_RESP_OK,
    ST_RESP_FAIL
  } state_t;

  typedef struct packed {
    logic cap;
    logic div_start;
    logic scan_clr;
    logic scan_inc;
    logic claim;
    logic claim_tr;
    logic frm_map;
    logic free_frame;
    logic load_commit;
    logic free_commit;
    logic mul;
    logic fin;
    logic fin_ok;
  } cmd_t;

  typedef struct packed {
    op_t  action;
    logic pid_ok;
    logic present;
    logic ps_zero;
    logic div_busy;
    logic need_gt_free;
    logic load_done;
    logic page_bad;
    logic map_loaded;
    logic free_none;
    logic cur_used;
    logic owner_hit;
    logic last_frame;
    logic out_busy;
  } st_t;

endpackage

[design/pfat_ram.sv]
module pfat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/pfat_div.sv]
module pfat_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [pfat_pkg::DVW-1:0] dividend,
  input  logic [pfat_pkg::PSW-1:0] divisor,
  output logic                    busy,
  output logic [pfat_pkg::DVW-1:0] quot,
  output logic [pfat_pkg::PSW-1:0] rem
);
  import pfat_pkg::*;

  localparam int CNTW = $clog2(DVW + 1);

  logic [DVW-1:0]  dvd;
  logic [PSW-1:0]  rmd;
  logic [CNTW-1:0] cnt;
  logic [PSW:0]    trial;
  logic [PSW:0]    diff;
  logic            ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rmd, dvd[DVW-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(DVW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rmd <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[DVW-2:0], ge};
      rmd <= ge ? diff[PSW-1:0] : trial[PSW-1:0];
    end
  end

  assign busy = cnt != '0;
  assign quot = dvd;
  assign rem  = rmd;

endmodule

[design/pfat_ctrl.sv]
module pfat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfat_pkg::st_t  st,
  output pfat_pkg::cmd_t cmd
);
  import pfat_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (!st.pid_ok) begin
          state_next = ST_RESP_FAIL;
        end else if (st.action == OP_LOAD || st.action == OP_XLATE) begin
          if (!st.ps_zero && (st.action == OP_XLATE) == st.present) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV_WAIT;
          end else begin
            state_next = ST_RESP_FAIL;
          end
        end else if (st.action == OP_FREE && st.present) begin
          cmd.scan_clr = 1'b1;
          state_next   = ST_FREE_RD;
        end else begin
          state_next = ST_RESP_FAIL;
        end
      end
      ST_DIV_WAIT: begin
        if (!st.div_busy) begin
          state_next = (st.action == OP_LOAD) ? ST_LOAD_CHK : ST_TR_CHK;
        end
      end
      ST_LOAD_CHK: begin
        if (st.need_gt_free) begin
          state_next = ST_RESP_FAIL;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = ST_LOAD_SCAN;
        end
      end
      ST_LOAD_SCAN: begin
        if (st.load_done) begin
          cmd.load_commit = 1'b1;
          state_next      = ST_RESP_OK;
        end else begin
          cmd.claim    = !st.cur_used;
          cmd.scan_inc = 1'b1;
        end
      end
      ST_TR_CHK: begin
        state_next = st.page_bad ? ST_RESP_FAIL : ST_TR_LOOK;
      end
      ST_TR_LOOK: begin
        if (st.map_loaded) begin
          cmd.frm_map = 1'b1;
          state_next  = ST_TR_MUL;
        end else if (st.free_none) begin
          state_next = ST_RESP_FAIL;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = ST_TR_SCAN;
        end
      end
      ST_TR_SCAN: begin
        if (!st.cur_used) begin
          cmd.claim    = 1'b1;
          cmd.claim_tr = 1'b1;
          state_next   = ST_TR_MUL;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_TR_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_RESP_OK;
      end
      ST_FREE_RD: begin
        state_next = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        cmd.free_frame = st.cur_used && st.owner_hit;
        if (st.last_frame) begin
          cmd.free_commit = 1'b1;
          state_next      = ST_RESP_OK;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = ST_FREE_RD;
        end
      end
      ST_RESP_OK, ST_RESP_FAIL: begin
        if (!st.out_busy) begin
          cmd.fin    = 1'b1;
          cmd.fin_ok = state == ST_RESP_OK;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/pfat_dpath.sv]
module pfat_dpath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [pfat_pkg::PSW-1:0] cfg_data,
  input  pfat_pkg::in_t            in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pfat_pkg::out_t           out_item,
  input  pfat_pkg::cmd_t           cmd,
  output pfat_pkg::st_t            st
);
  import pfat_pkg::*;

  logic [PSW-1:0]        page_size;
  in_t                   item;
  logic [NUM_FRAMES-1:0] frame_used;
  logic [CW-1:0]         free_cnt;
  logic [MAX_PROCESSES-1:0] present;
  logic [CW-1:0]         page_count [MAX_PROCESSES];
  logic [FW-1:0]         fcnt;
  logic [CW-1:0]         pcnt;
  logic [FW-1:0]         frm;
  logic [PRODW-1:0]      prod;
  logic [PRODW-1:0]      sum;

  logic                  div_busy;
  logic [DVW-1:0]        quot;
  logic [PSW-1:0]        rem;
  logic [NEEDW-1:0]      need;

  logic [PIDW-1:0]       owner_rdata;
  logic [FW:0]           map_rdata;
  logic [FW-1:0]         claim_page;

  pfat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (item.action == OP_LOAD ? item.memory_size : item.logical_address),
    .divisor  (page_size),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  // Rounded-up page count for a load.
  assign need       = NEEDW'(quot) + NEEDW'(rem != '0);
  assign claim_page = cmd.claim_tr ? quot[FW-1:0] : pcnt[FW-1:0];

  pfat_ram #(.WIDTH(PIDW), .DEPTH(NUM_FRAMES)) u_owner (
    .clk   (clk),
    .we    (cmd.claim),
    .waddr (fcnt),
    .wdata (item.process_id),
    .raddr (fcnt),
    .rdata (owner_rdata)
  );

  // Each entry holds a loaded flag above the frame number.
  pfat_ram #(.WIDTH(FW + 1), .DEPTH(MAX_PROCESSES * NUM_FRAMES)) u_map (
    .clk   (clk),
    .we    (cmd.claim),
    .waddr ({item.process_id, claim_page}),
    .wdata ({1'b1, fcnt}),
    .raddr ({item.process_id, quot[FW-1:0]}),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size  <= PS_RESET;
      frame_used <= '0;
      free_cnt   <= CW'(NUM_FRAMES);
      present    <= '0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        page_count[i] <= '0;
      end
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_size <= cfg_data;
      end
      if (cmd.claim) begin
        frame_used[fcnt] <= 1'b1;
        free_cnt         <= free_cnt - 1'b1;
      end else if (cmd.free_frame) begin
        frame_used[fcnt] <= 1'b0;
        free_cnt         <= free_cnt + 1'b1;
      end
      if (cmd.load_commit) begin
        present[item.process_id]    <= 1'b1;
        page_count[item.process_id] <= need[CW-1:0];
      end else if (cmd.free_commit) begin
        present[item.process_id]    <= 1'b0;
        page_count[item.process_id] <= '0;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sum = prod + PRODW'(rem);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item <= in_item;
    end
    if (cmd.scan_clr) begin
      fcnt <= '0;
      pcnt <= '0;
    end else begin
      if (cmd.scan_inc) begin
        fcnt <= fcnt + 1'b1;
      end
      if (cmd.claim && !cmd.claim_tr) begin
        pcnt <= pcnt + 1'b1;
      end
    end
    if (cmd.frm_map) begin
      frm <= map_rdata[FW-1:0];
    end else if (cmd.claim_tr) begin
      frm <= fcnt;
    end
    if (cmd.mul) begin
      prod <= PRODW'(frm) * PRODW'(page_size);
    end
    if (cmd.fin) begin
      out_item.ok               <= cmd.fin_ok;
      out_item.physical_address <= (cmd.fin_ok && item.action == OP_XLATE) ?
                                   sum[PAW-1:0] : '0;
    end
  end

  always_comb begin
    st              = '0;
    st.action       = item.action;
    st.pid_ok       = 32'(item.process_id) < MAX_PROCESSES;
    st.present      = present[item.process_id];
    st.ps_zero      = page_size == '0;
    st.div_busy     = div_busy;
    st.need_gt_free = need > NEEDW'(free_cnt);
    st.load_done    = NEEDW'(pcnt) == need;
    st.page_bad     = quot >= DVW'(page_count[item.process_id]);
    st.map_loaded   = map_rdata[FW];
    st.free_none    = free_cnt == '0;
    st.cur_used     = frame_used[fcnt];
    st.owner_hit    = owner_rdata == item.process_id;
    st.last_frame   = fcnt == FW'(NUM_FRAMES - 1);
    st.out_busy     = out_valid && !out_ready;
  end

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    32'(free_cnt) == NUM_FRAMES - $countones(frame_used))
    else $error("free frame count out of step with frame map");

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    cmd.claim |-> !frame_used[fcnt])
    else $error("claim of a frame already in use");

  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !(out_valid && !out_ready))
    else $error("result written over a result not yet taken");

  a_release_used: assert property (@(posedge clk) disable iff (rst)
    cmd.free_frame |-> frame_used[fcnt])
    else $error("release of a frame not in use");

endmodule

[design/paged_frame_allocator_translator.sv]
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_item (action, process_id, size, address)
// out     | output    | out_valid / out_ready | out_item (ok, physical_address)
// cfg     | input     | cfg_we                | cfg_data (page size)
//
// One item is worked at a time; in_ready is high only while the controller is idle.
// A load runs the 24-step divider for the page count, then scans the frames, up to 64,
// claiming free ones. A translate runs the divider and, on a page fault, scans up
// to 64 frames for a free one. A deallocate reads and checks each of the 64 frames in turn.
// Reset is synchronous; it frees every frame, clears the process table and sets
// the page size to 4096. A held result does not block the next transfer in.
module paged_frame_allocator_translator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pfat_pkg::in_t            in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pfat_pkg::out_t           out_item,
  input  logic                     cfg_we,
  input  logic [pfat_pkg::PSW-1:0] cfg_data
);
  import pfat_pkg::*;

  // The controller sequences each operation; the datapath holds the frame
  // map, process table, divider, page table memory and the result register.
  cmd_t cmd;
  st_t  st;

  pfat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pfat_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
